/* design/light_fade_blink_controller_macros.svh */
// assertion macros for the lamp fade and blink controller checker
`ifndef LIGHT_FADE_BLINK_CONTROLLER_MACROS_SVH
`define LIGHT_FADE_BLINK_CONTROLLER_MACROS_SVH

// implication checked in the same cycle, disabled during reset
`define LFB_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("lfb checker: property failed");

// implication checked in the following cycle, disabled during reset
`define LFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("lfb checker: property failed");

`endif

/* design/lfb_pkg.sv */
// types, constants and fade step functions shared by the lamp controller
`default_nettype none

package lfb_pkg;

  localparam int NUM_LAMPS_DEF = 16;
  localparam int LEVEL_W       = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int BRIGHT_SHIFT  = 3;

  typedef enum logic [1:0] {
    CMD_SERVICE = 2'd0,
    CMD_ASPECT  = 2'd1,
    CMD_ROAD    = 2'd2,
    CMD_BRIGHT  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    MODE_OFF        = 4'd0,
    MODE_ON         = 4'd1,
    MODE_RAMP_ON    = 4'd2,
    MODE_RAMP_OFF   = 4'd3,
    MODE_BRIGHT     = 4'd4,
    MODE_BLINK_WAIT = 4'd5,
    MODE_BLINK_RISE = 4'd6,
    MODE_BLINK_FALL = 4'd7,
    MODE_ROAD_DARK  = 4'd8,
    MODE_ROAD_RISE  = 4'd9,
    MODE_ROAD_LIT   = 4'd10,
    MODE_ROAD_FALL  = 4'd11,
    MODE_ROAD_START = 4'd12,
    MODE_ROAD_FINAL = 4'd13
  } mode_t;

  localparam logic [1:0] ASPECT_OFF   = 2'd0;
  localparam logic [1:0] ASPECT_BLINK = 2'd1;
  localparam logic [1:0] ASPECT_ON    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_DARK_WAIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROAD_WAIT       = 3'd4;

  localparam logic [7:0] PWM_TOP_RST         = 8'd31;
  localparam logic [7:0] FAST_THRESHOLD_RST  = 8'd8;
  localparam logic [6:0] FAST_STEP_RST       = 7'd2;
  localparam logic [7:0] BLINK_DARK_WAIT_RST = 8'd16;
  localparam logic [7:0] ROAD_WAIT_RST       = 8'd24;
  localparam logic [7:0] LEVEL_MAX           = 8'hFF;

  typedef struct packed {
    logic [7:0] pwm_top;
    logic [7:0] fast_threshold;
    logic [6:0] fast_step;
    logic [7:0] blink_dark_wait;
    logic [7:0] road_wait;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [LEVEL_W-1:0] level;
  } lamp_t;

  localparam lamp_t LAMP_RESET = '{mode: MODE_OFF, level: 8'd0};

  typedef struct packed {
    cmd_t       command;
    logic [3:0] lamp_index;
    logic [3:0] partner_index;
    logic [7:0] pwm_phase;
    logic       advance;
    logic [7:0] payload;
  } item_t;

  typedef struct packed {
    logic  wr_a;
    lamp_t lamp_a;
    logic  wr_b;
    lamp_t lamp_b;
    logic  drive;
    lamp_t result;
  } step_res_t;

  function automatic logic [7:0] step_up(input logic [7:0] v, input logic dbl, input cfg_t c);
    logic [8:0] inc;
    logic [8:0] sum;
    if (v > c.fast_threshold) begin
      inc = dbl ? {1'b0, c.fast_step, 1'b0} : {2'b00, c.fast_step};
    end else begin
      inc = dbl ? 9'd2 : 9'd1;
    end
    sum = {1'b0, v} + inc;
    return (sum > {1'b0, c.pwm_top}) ? c.pwm_top : sum[7:0];
  endfunction

  function automatic logic [7:0] step_down(input logic [7:0] v, input logic dbl,
                                           input cfg_t c);
    logic [7:0] d;
    if (v > c.fast_threshold) begin
      d = dbl ? {c.fast_step, 1'b0} : {1'b0, c.fast_step};
    end else begin
      d = dbl ? 8'd2 : 8'd1;
    end
    return (d > v) ? 8'd0 : v - d;
  endfunction

  function automatic mode_t road_off(input mode_t m);
    return (m == MODE_ROAD_DARK || m == MODE_ROAD_START) ? MODE_OFF : MODE_ROAD_FINAL;
  endfunction

  function automatic logic lamp_drive(input lamp_t l, input logic [7:0] phase);
    logic d;
    case (l.mode) inside
      MODE_ON, MODE_ROAD_LIT: d = 1'b1;
      MODE_RAMP_ON, MODE_RAMP_OFF, MODE_BRIGHT, MODE_BLINK_RISE, MODE_BLINK_FALL,
      MODE_ROAD_RISE, MODE_ROAD_FALL, MODE_ROAD_FINAL: d = (phase < l.level);
      default: d = 1'b0;
    endcase
    return d;
  endfunction

  function automatic lamp_t fade(input lamp_t l, input cfg_t c);
    lamp_t      r;
    logic [7:0] v;
    r = l;
    v = l.level;
    case (l.mode) inside
      MODE_RAMP_ON: begin
        if (v >= c.pwm_top) r.mode = MODE_ON;
        else r.level = step_up(v, 1'b1, c);
      end
      MODE_RAMP_OFF: begin
        if (v == 8'd0) r.mode = MODE_OFF;
        else r.level = step_down(v, 1'b1, c);
      end
      MODE_BLINK_WAIT: begin
        if (v >= c.blink_dark_wait) begin
          r.mode  = MODE_BLINK_RISE;
          r.level = 8'd0;
        end else if (v != LEVEL_MAX) begin
          r.level = v + 8'd1;
        end
      end
      MODE_BLINK_RISE: begin
        if (v >= c.pwm_top) begin
          r.mode  = MODE_BLINK_FALL;
          r.level = ({1'b0, c.fast_step} > v) ? 8'd0 : v - {1'b0, c.fast_step};
        end else begin
          r.level = step_up(v, 1'b0, c);
        end
      end
      MODE_BLINK_FALL: begin
        if (v == 8'd0) begin
          r.mode  = MODE_BLINK_WAIT;
          r.level = 8'd1;
        end else begin
          r.level = step_down(v, 1'b0, c);
        end
      end
      MODE_ROAD_DARK: begin
        if (v >= c.road_wait) begin
          r.mode  = MODE_ROAD_RISE;
          r.level = 8'd0;
        end else begin
          r.level = step_up(v, 1'b0, c);
        end
      end
      MODE_ROAD_RISE: begin
        if (v >= c.pwm_top) begin
          r.mode  = MODE_ROAD_LIT;
          r.level = 8'd0;
        end else begin
          r.level = step_up(v, 1'b1, c);
        end
      end
      MODE_ROAD_LIT: begin
        if (v >= c.road_wait) r.mode = MODE_ROAD_FALL;
        else r.level = step_up(v, 1'b0, c);
      end
      MODE_ROAD_FALL, MODE_ROAD_START: begin
        if (v == 8'd0) r.mode = MODE_ROAD_DARK;
        else r.level = step_down(v, 1'b1, c);
      end
      MODE_ROAD_FINAL: begin
        if (v == 8'd0) r.mode = MODE_OFF;
        else r.level = step_down(v, 1'b1, c);
      end
      default: r = l;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/lfb_store.sv */
// lamp state memory, two registered reads, one write, valid bits and write bypass
`default_nettype none

module lfb_store import lfb_pkg::*; #(
  parameter int NUM_LAMPS = NUM_LAMPS_DEF,
  parameter int LW        = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [LW-1:0] ra,
  input  wire logic [LW-1:0] rb,
  input  wire logic          we,
  input  wire logic [LW-1:0] wa,
  input  wire lamp_t         wd,
  output lamp_t              qa,
  output lamp_t              qb
);

  lamp_t                mem [NUM_LAMPS];
  logic [NUM_LAMPS-1:0] vld;
  lamp_t                mem_a;
  lamp_t                mem_b;
  logic                 vld_a;
  logic                 vld_b;
  logic [LW-1:0]        ra_q;
  logic [LW-1:0]        rb_q;
  logic                 lw_valid;
  logic [LW-1:0]        lw_addr;
  lamp_t                lw_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_a   <= mem[ra];
    mem_b   <= mem[rb];
    ra_q    <= ra;
    rb_q    <= rb;
    vld_a   <= vld[ra];
    vld_b   <= vld[rb];
    lw_addr <= wa;
    lw_data <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      lw_valid <= 1'b0;
    end else begin
      if (we) begin
        vld[wa] <= 1'b1;
      end
      lw_valid <= we;
    end
  end

  // write at the read edge is not yet in the registered read data
  assign qa = (lw_valid && lw_addr == ra_q) ? lw_data : (vld_a ? mem_a : LAMP_RESET);
  assign qb = (lw_valid && lw_addr == rb_q) ? lw_data : (vld_b ? mem_b : LAMP_RESET);

endmodule

`default_nettype wire

/* design/lfb_step.sv */
// command decode and fade step for one item
`default_nettype none

module lfb_step import lfb_pkg::*; #(
  parameter int NUM_LAMPS = NUM_LAMPS_DEF
) (
  input  wire item_t  item,
  input  wire cfg_t   cfg,
  input  wire lamp_t  cur_a,
  input  wire lamp_t  cur_b,
  output step_res_t   res
);

  logic  a_ok;
  logic  b_ok;
  logic  same;
  logic  on;
  logic  drv;
  lamp_t nxt_a;
  lamp_t nxt_b;
  lamp_t src_b;
  lamp_t fin_a;

  always_comb begin
    a_ok  = int'(item.lamp_index) < NUM_LAMPS;
    b_ok  = int'(item.partner_index) < NUM_LAMPS;
    same  = item.partner_index == item.lamp_index;
    on    = item.payload == 8'd1;
    drv   = 1'b0;
    nxt_a = cur_a;
    nxt_b = cur_b;
    src_b = cur_b;
    fin_a = cur_a;
    unique case (item.command)
      CMD_SERVICE: begin
        drv = lamp_drive(cur_a, item.pwm_phase);
        if (item.advance) nxt_a = fade(cur_a, cfg);
        fin_a = nxt_a;
      end
      CMD_ASPECT: begin
        case (item.payload[1:0])
          ASPECT_OFF:   nxt_a.mode = MODE_RAMP_OFF;
          ASPECT_BLINK: nxt_a.mode = MODE_BLINK_RISE;
          ASPECT_ON:    nxt_a.mode = MODE_RAMP_ON;
          default:      nxt_a.mode = cur_a.mode;
        endcase
        fin_a = nxt_a;
      end
      CMD_ROAD: begin
        if (on) begin
          nxt_a = '{mode: MODE_ROAD_START, level: cfg.pwm_top};
        end else begin
          nxt_a.mode = road_off(cur_a.mode);
        end
        // same lamp twice: partner half sees the first half's result and wins
        src_b = same ? nxt_a : cur_b;
        if (on) begin
          nxt_b = '{mode: MODE_ROAD_RISE, level: 8'd0};
        end else begin
          nxt_b = '{mode: road_off(src_b.mode), level: src_b.level};
        end
        fin_a = (b_ok && same) ? nxt_b : nxt_a;
      end
      CMD_BRIGHT: begin
        nxt_a = '{mode: MODE_BRIGHT, level: item.payload >> BRIGHT_SHIFT};
        fin_a = nxt_a;
      end
    endcase

    res.wr_a   = a_ok;
    res.lamp_a = fin_a;
    res.wr_b   = a_ok && b_ok && !same && item.command == CMD_ROAD;
    res.lamp_b = nxt_b;
    res.drive  = a_ok && drv;
    res.result = a_ok ? fin_a : LAMP_RESET;
  end

endmodule

`default_nettype wire

/* design/light_fade_blink_controller.sv */
// top level of the lamp fade and blink controller
//
// Items enter on start while busy is low; the command field selects a lamp
// service (pwm sample plus optional fade step), an aspect change, a road pair
// switch or a brightness load. Every item, including one addressing a lamp
// beyond the lamp count, gives exactly one result on drive, mode_now and
// level_now, marked by done for one cycle.
// Items may be accepted every cycle while busy is low; the lamp store is read
// at acceptance and written in the following cycle, with a bypass for back to back items on one lamp.
// A road pair switch whose partner is a different valid lamp needs a second
// write on the single store write port, so busy is high while that item is
// being stepped and while its partner write is pending.
// The result side has no backpressure: done is a strobe and results are
// never held. Configuration writes use cfg_valid/cfg_ready (always ready),
// cfg_index selects the register, and are expected while no item is in
// flight. Reset is synchronous: all lamps off at level zero, registers at
// their defaults, busy high while reset is asserted.
`default_nettype none

module light_fade_blink_controller import lfb_pkg::*; #(
  parameter int NUM_LAMPS = NUM_LAMPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           command,
  input  wire logic [3:0]           lamp_index,
  input  wire logic [3:0]           partner_index,
  input  wire logic [7:0]           pwm_phase,
  input  wire logic                 advance,
  input  wire logic [7:0]           payload,
  output logic                      done,
  output logic                      drive,
  output logic [3:0]                mode_now,
  output logic [7:0]                level_now,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int LW = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;

  cfg_t          cfg;
  item_t         item;
  logic          item_valid;
  logic          pw_valid;
  logic [LW-1:0] pw_addr;
  lamp_t         pw_data;
  logic          accept;
  lamp_t         cur_a;
  lamp_t         cur_b;
  step_res_t     step_res;
  logic          we;
  logic [LW-1:0] wa;
  lamp_t         wd;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = rst || pw_valid || (item_valid && step_res.wr_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{pwm_top: PWM_TOP_RST, fast_threshold: FAST_THRESHOLD_RST,
               fast_step: FAST_STEP_RST, blink_dark_wait: BLINK_DARK_WAIT_RST,
               road_wait: ROAD_WAIT_RST};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PWM_TOP:         cfg.pwm_top         <= cfg_data;
        REG_FAST_THRESHOLD:  cfg.fast_threshold  <= cfg_data;
        REG_FAST_STEP:       cfg.fast_step       <= cfg_data[6:0];
        REG_BLINK_DARK_WAIT: cfg.blink_dark_wait <= cfg_data;
        REG_ROAD_WAIT:       cfg.road_wait       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      pw_valid   <= 1'b0;
      done       <= 1'b0;
    end else begin
      item_valid <= accept;
      pw_valid   <= item_valid && step_res.wr_b;
      done       <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= '{command: cmd_t'(command), lamp_index: lamp_index,
                partner_index: partner_index, pwm_phase: pwm_phase,
                advance: advance, payload: payload};
    end
    pw_addr   <= LW'(item.partner_index);
    pw_data   <= step_res.lamp_b;
    drive     <= step_res.drive;
    mode_now  <= step_res.result.mode;
    level_now <= step_res.result.level;
  end

  assign we = pw_valid || (item_valid && step_res.wr_a);
  assign wa = pw_valid ? pw_addr : LW'(item.lamp_index);
  assign wd = pw_valid ? pw_data : step_res.lamp_a;

  lfb_store #(
    .NUM_LAMPS (NUM_LAMPS),
    .LW        (LW)
  ) u_store (
    .clk (clk),
    .rst (rst),
    .ra  (LW'(lamp_index)),
    .rb  (LW'(partner_index)),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .qa  (cur_a),
    .qb  (cur_b)
  );

  lfb_step #(
    .NUM_LAMPS (NUM_LAMPS)
  ) u_step (
    .item  (item),
    .cfg   (cfg),
    .cur_a (cur_a),
    .cur_b (cur_b),
    .res   (step_res)
  );

endmodule

`default_nettype wire

/* design/lfb_checker.sv */
// port level checker for the lamp fade and blink controller, with its bind
`default_nettype none

`include "light_fade_blink_controller_macros.svh"

module lfb_checker import lfb_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] command,
  input wire logic       done
);

  `LFB_ASSERT(a_done_latency, start && !busy, ##2 done)
  `LFB_ASSERT(a_done_source, done, $past(start && !busy, 2))
  `LFB_ASSERT(a_busy_cause, $rose(busy), $past(start && command == CMD_ROAD))
  `LFB_ASSERT_NEXT(a_busy_short, busy && $past(busy), !busy)

endmodule

bind light_fade_blink_controller lfb_checker u_lfb_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .command (command),
  .done    (done)
);

`default_nettype wire

/* tb/light_fade_blink_controller_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the lamp fade and blink controller
module light_fade_blink_controller_tb;
  import lfb_pkg::*;

  localparam int LAMPS = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 60;

  typedef struct packed {
    logic       drive;
    logic [3:0] mode;
    logic [7:0] level;
  } lamp_view_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           command = CMD_SERVICE;
  logic [3:0]           lamp_index = '0;
  logic [3:0]           partner_index = '0;
  logic [7:0]           pwm_phase = '0;
  logic                 advance = 1'b0;
  logic [7:0]           payload = '0;
  logic                 done;
  logic                 drive;
  logic [3:0]           mode_now;
  logic [7:0]           level_now;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  item_t      pending_q[$];
  lamp_view_t view_q[$];

  mode_t      mode_tbl[LAMPS];
  logic [7:0] level_tbl[LAMPS];
  int         top_lvl, fast_thr, fast_inc, blink_wait, road_hold;

  int issue_cnt = 0;
  int accept_cnt = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  bit burst = 1'b0;
  bit drain_hold = 1'b0;

  light_fade_blink_controller u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .lamp_index    (lamp_index),
    .partner_index (partner_index),
    .pwm_phase     (pwm_phase),
    .advance       (advance),
    .payload       (payload),
    .done          (done),
    .drive         (drive),
    .mode_now      (mode_now),
    .level_now     (level_now),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int rise(int v, int mul);
    int r;
    r = (v > fast_thr) ? v + fast_inc * mul : v + mul;
    return (r > top_lvl) ? top_lvl : r;
  endfunction

  function automatic int fall(int v, int mul);
    int d;
    d = (v > fast_thr) ? fast_inc * mul : mul;
    return (d > v) ? 0 : v - d;
  endfunction

  function automatic mode_t road_release(mode_t m);
    return (m == MODE_ROAD_DARK || m == MODE_ROAD_START) ? MODE_OFF : MODE_ROAD_FINAL;
  endfunction

  task automatic fade_lamp(input int i);
    mode_t m;
    int    v;
    m = mode_tbl[i];
    v = level_tbl[i];
    case (m)
      MODE_RAMP_ON: begin
        if (v >= top_lvl) m = MODE_ON;
        else v = rise(v, 2);
      end
      MODE_RAMP_OFF: begin
        if (v == 0) m = MODE_OFF;
        else v = fall(v, 2);
      end
      MODE_BLINK_WAIT: begin
        if (v >= blink_wait) begin
          m = MODE_BLINK_RISE;
          v = 0;
        end else if (v < 255) begin
          v = v + 1;
        end
      end
      MODE_BLINK_RISE: begin
        if (v >= top_lvl) begin
          m = MODE_BLINK_FALL;
          v = (fast_inc > v) ? 0 : v - fast_inc;
        end else begin
          v = rise(v, 1);
        end
      end
      MODE_BLINK_FALL: begin
        if (v == 0) begin
          m = MODE_BLINK_WAIT;
          v = 1;
        end else begin
          v = fall(v, 1);
        end
      end
      MODE_ROAD_DARK: begin
        if (v >= road_hold) begin
          m = MODE_ROAD_RISE;
          v = 0;
        end else begin
          v = rise(v, 1);
        end
      end
      MODE_ROAD_RISE: begin
        if (v >= top_lvl) begin
          m = MODE_ROAD_LIT;
          v = 0;
        end else begin
          v = rise(v, 2);
        end
      end
      MODE_ROAD_LIT: begin
        if (v >= road_hold) m = MODE_ROAD_FALL;
        else v = rise(v, 1);
      end
      MODE_ROAD_FALL, MODE_ROAD_START: begin
        if (v == 0) m = MODE_ROAD_DARK;
        else v = fall(v, 2);
      end
      MODE_ROAD_FINAL: begin
        if (v == 0) m = MODE_OFF;
        else v = fall(v, 2);
      end
      default: ;
    endcase
    mode_tbl[i] = m;
    level_tbl[i] = 8'(v);
  endtask

  task automatic predict_item(input item_t it);
    lamp_view_t v;
    int         a;
    int         b;
    a = it.lamp_index;
    b = it.partner_index;
    v.drive = 1'b0;
    case (it.command)
      CMD_SERVICE: begin
        case (mode_tbl[a])
          MODE_ON, MODE_ROAD_LIT: v.drive = 1'b1;
          MODE_RAMP_ON, MODE_RAMP_OFF, MODE_BRIGHT, MODE_BLINK_RISE, MODE_BLINK_FALL,
          MODE_ROAD_RISE, MODE_ROAD_FALL, MODE_ROAD_FINAL: begin
            v.drive = (it.pwm_phase < level_tbl[a]);
          end
          default: v.drive = 1'b0;
        endcase
        if (it.advance) fade_lamp(a);
      end
      CMD_ASPECT: begin
        case (it.payload[1:0])
          ASPECT_OFF:   mode_tbl[a] = MODE_RAMP_OFF;
          ASPECT_BLINK: mode_tbl[a] = MODE_BLINK_RISE;
          ASPECT_ON:    mode_tbl[a] = MODE_RAMP_ON;
          default: ;
        endcase
      end
      CMD_ROAD: begin
        if (it.payload == 8'd1) begin
          mode_tbl[a] = MODE_ROAD_START;
          level_tbl[a] = 8'(top_lvl);
          mode_tbl[b] = MODE_ROAD_RISE;
          level_tbl[b] = 8'd0;
        end else begin
          mode_tbl[a] = road_release(mode_tbl[a]);
          mode_tbl[b] = road_release(mode_tbl[b]);
        end
      end
      default: begin
        mode_tbl[a] = MODE_BRIGHT;
        level_tbl[a] = it.payload >> BRIGHT_SHIFT;
      end
    endcase
    v.mode = mode_tbl[a];
    v.level = level_tbl[a];
    view_q.push_back(v);
  endtask

  function automatic item_t lamp_item(cmd_t c, logic [3:0] a, logic [3:0] b,
                                      logic [7:0] ph, logic adv, logic [7:0] pay);
    item_t it;
    it.command = c;
    it.lamp_index = a;
    it.partner_index = b;
    it.pwm_phase = ph;
    it.advance = adv;
    it.payload = pay;
    return it;
  endfunction

  function automatic item_t noise_item();
    return lamp_item(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] pick_phase();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, top_lvl)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t service_item(int lamp);
    return lamp_item(CMD_SERVICE, 4'(lamp), 4'($urandom_range(0, 15)), pick_phase(),
                     1'($urandom_range(0, 7) != 0), 8'($urandom_range(0, 255)));
  endfunction

  // an optional lamp command followed by a run of fade steps, with stray items mixed in
  task automatic queue_sequence(inout int n);
    int         lamp;
    int         mate;
    int         pick;
    int         run;
    logic [7:0] pay;
    lamp = $urandom_range(0, LAMPS - 1);
    mate = ($urandom_range(0, 5) == 0) ? lamp : $urandom_range(0, LAMPS - 1);
    pick = $urandom_range(0, 9);
    pay = 8'($urandom_range(0, 255));
    if (pick < 3) begin
      if ($urandom_range(0, 4) != 0) pay[1:0] = 2'($urandom_range(0, 2));
      pending_q.push_back(lamp_item(CMD_ASPECT, 4'(lamp), 4'(mate), pick_phase(), 1'b0, pay));
    end else if (pick < 6) begin
      if ($urandom_range(0, 3) != 0) pay = 8'd1;
      pending_q.push_back(lamp_item(CMD_ROAD, 4'(lamp), 4'(mate), pick_phase(), 1'b1, pay));
    end else if (pick < 8) begin
      pending_q.push_back(lamp_item(CMD_BRIGHT, 4'(lamp), 4'(mate), pick_phase(), 1'b1, pay));
    end
    n = n + 1;
    run = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 300) : $urandom_range(5, 40);
    for (int k = 0; k < run; k++) begin
      if ($urandom_range(0, 9) == 0) pending_q.push_back(noise_item());
      else if (pick >= 3 && pick < 6 && $urandom_range(0, 1)) pending_q.push_back(service_item(mate));
      else pending_q.push_back(service_item(lamp));
    end
    n = n + run;
    if (pick >= 3 && pick < 6 && $urandom_range(0, 2) == 0) begin
      pending_q.push_back(lamp_item(CMD_ROAD, 4'(lamp), 4'(mate), pick_phase(), 1'b0, 8'd0));
      for (int k = 0; k < 8; k++) pending_q.push_back(service_item(k[0] ? mate : lamp));
      n = n + 9;
    end
  endtask

  task automatic queue_directed();
    pending_q.push_back(lamp_item(CMD_SERVICE, 4'd0, 4'd0, 8'd0, 1'b1, 8'd0));
    pending_q.push_back(lamp_item(CMD_BRIGHT, 4'd0, 4'd0, 8'd0, 1'b0, 8'hFF));
    pending_q.push_back(lamp_item(CMD_SERVICE, 4'd0, 4'd0, 8'd0, 1'b0, 8'd0));
    pending_q.push_back(lamp_item(CMD_SERVICE, 4'd0, 4'd0, 8'hFF, 1'b1, 8'd0));
    pending_q.push_back(lamp_item(CMD_BRIGHT, 4'd15, 4'd0, 8'd0, 1'b0, 8'h00));
    pending_q.push_back(lamp_item(CMD_SERVICE, 4'd15, 4'd15, 8'hFF, 1'b1, 8'hFF));
    pending_q.push_back(lamp_item(CMD_ASPECT, 4'd1, 4'd0, 8'd0, 1'b0, 8'h02));
    repeat (3) pending_q.push_back(lamp_item(CMD_SERVICE, 4'd1, 4'd0, 8'd1, 1'b1, 8'd0));
    // aspect code three keeps the ramp going
    pending_q.push_back(lamp_item(CMD_ASPECT, 4'd1, 4'd0, 8'd0, 1'b0, 8'hFF));
    pending_q.push_back(lamp_item(CMD_SERVICE, 4'd1, 4'd0, 8'd3, 1'b0, 8'd0));
    pending_q.push_back(lamp_item(CMD_ASPECT, 4'd1, 4'd0, 8'd0, 1'b0, 8'h00));
    pending_q.push_back(lamp_item(CMD_SERVICE, 4'd1, 4'd0, 8'd0, 1'b1, 8'd0));
    pending_q.push_back(lamp_item(CMD_ASPECT, 4'd2, 4'd0, 8'd0, 1'b0, 8'h01));
    repeat (2) pending_q.push_back(lamp_item(CMD_SERVICE, 4'd2, 4'd0, 8'd0, 1'b1, 8'd0));
    pending_q.push_back(lamp_item(CMD_ROAD, 4'd3, 4'd4, 8'd0, 1'b0, 8'd1));
    pending_q.push_back(lamp_item(CMD_SERVICE, 4'd4, 4'd0, 8'd0, 1'b1, 8'd0));
    // road off: start lamp goes off, rising partner goes to final off
    pending_q.push_back(lamp_item(CMD_ROAD, 4'd3, 4'd4, 8'd0, 1'b0, 8'd0));
    pending_q.push_back(lamp_item(CMD_SERVICE, 4'd4, 4'd0, 8'd0, 1'b1, 8'd0));
    // same lamp on both sides of the pair
    pending_q.push_back(lamp_item(CMD_ROAD, 4'd5, 4'd5, 8'd0, 1'b0, 8'd1));
    pending_q.push_back(lamp_item(CMD_ROAD, 4'd5, 4'd5, 8'd0, 1'b0, 8'd2));
    pending_q.push_back(lamp_item(CMD_ROAD, 4'd6, 4'd7, 8'd0, 1'b0, 8'hFF));
    pending_q.push_back(lamp_item(CMD_SERVICE, 4'd6, 4'd0, 8'd0, 1'b1, 8'd0));
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || issue_cnt != accept_cnt || view_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 8'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_phase(input int ph);
    int top, thr, stp, bw, rw;
    case (ph)
      1: begin
        top = 1; thr = 0; stp = 1; bw = 0; rw = 0;
      end
      2: begin
        top = 255; thr = 255; stp = 64; bw = 255; rw = 255;
      end
      3: begin
        top = 255; thr = 0; stp = 64; bw = 255; rw = 0;
      end
      default: begin
        top = $urandom_range(1, 63);
        thr = $urandom_range(0, 40);
        stp = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
        bw = $urandom_range(0, 20);
        rw = $urandom_range(0, 40);
      end
    endcase
    write_reg(REG_PWM_TOP, top);
    write_reg(REG_FAST_THRESHOLD, thr);
    write_reg(REG_FAST_STEP, stp);
    write_reg(REG_BLINK_DARK_WAIT, bw);
    write_reg(REG_ROAD_WAIT, rw);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result checking, config tracking and prediction of accepted items
  always @(posedge clk) begin
    lamp_view_t got;
    lamp_view_t want;
    item_t      seen;
    if (!rst) begin
      if (done) begin
        got = '{drive: drive, mode: mode_now, level: level_now};
        if (view_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: drive %0d mode %0d level %0d",
                     got.drive, got.mode, got.level);
        end else begin
          want = view_q.pop_front();
          if (got.drive !== want.drive || got.mode !== want.mode || got.level !== want.level) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected drive %0d mode %0d level %0d, got %0d %0d %0d",
                       want.drive, want.mode, want.level, got.drive, got.mode, got.level);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PWM_TOP:         top_lvl = cfg_data;
          REG_FAST_THRESHOLD:  fast_thr = cfg_data;
          REG_FAST_STEP:       fast_inc = cfg_data[6:0];
          REG_BLINK_DARK_WAIT: blink_wait = cfg_data;
          REG_ROAD_WAIT:       road_hold = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        seen = lamp_item(cmd_t'(command), lamp_index, partner_index, pwm_phase, advance,
                         payload);
        predict_item(seen);
        accept_cnt++;
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    logic  nxt;
    item_t it;
    nxt = start;
    if (rst) begin
      nxt = 1'b0;
    end else if (!start || accept_cnt == issue_cnt) begin
      nxt = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0 && !(drain_hold && view_q.size() > 0)) begin
        it = pending_q.pop_front();
        command <= it.command;
        lamp_index <= it.lamp_index;
        partner_index <= it.partner_index;
        pwm_phase <= it.pwm_phase;
        advance <= it.advance;
        payload <= it.payload;
        nxt = 1'b1;
        issue_cnt++;
        if ($urandom_range(0, 31) == 0) burst = !burst;
        gap_left = burst ? 0 : $urandom_range(0, 5);
        drain_hold = ($urandom_range(0, 63) == 0);
      end
    end
    start <= nxt;
  end

  initial begin
    int queued;
    for (int i = 0; i < LAMPS; i++) begin
      mode_tbl[i] = MODE_OFF;
      level_tbl[i] = 8'd0;
    end
    top_lvl = PWM_TOP_RST;
    fast_thr = FAST_THRESHOLD_RST;
    fast_inc = FAST_STEP_RST;
    blink_wait = BLINK_DARK_WAIT_RST;
    road_hold = ROAD_WAIT_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    queue_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph > 0) program_phase(ph);
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          pending_q.push_back(noise_item());
          queued++;
        end else begin
          queue_sequence(queued);
        end
      end
    end
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* light_fade_blink_controller.f */
+incdir+design
design/lfb_pkg.sv
design/lfb_store.sv
design/lfb_step.sv
design/light_fade_blink_controller.sv
design/lfb_checker.sv
tb/light_fade_blink_controller_tb.sv
